### hdl/ksf_pkg.sv
// ----------------------------------------------------------------------------
// ksf_pkg
// Shared widths, constants, codes and control structs for the speed fusion
// Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ksf_pkg;

  // fixed point
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int ACT_W     = 2;
  localparam int VAL_W     = 24;
  localparam int DT_W      = 16;
  localparam int REG_W     = 24;
  localparam int SPEED_W   = 23;
  localparam int KMH_W     = 25;
  localparam int COV_W     = 26;
  localparam int CFG_IDX_W = 3;

  // internal widths
  localparam int K_W       = FRAC_BITS + 1;          // gain, 0..1.0
  localparam int C36_W     = FRAC_BITS + 2;
  localparam int DEN_W     = COV_W + 1;              // P + R
  localparam int SUM_W     = COV_W;                  // signed speed before clamp
  localparam int MUL_A_W   = COV_W + 1;
  localparam int MUL_B_W   = C36_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int RS_W      = PROD_W - FRAC_BITS;
  localparam int DIV_STEPS = K_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [K_W-1:0]   ONE_K   = K_W'(1) << FRAC_BITS;
  localparam logic [C36_W-1:0] C36     = C36_W'(((36 << FRAC_BITS) + 5) / 10);
  localparam logic [COV_W-1:0] COV_MAX = '1;

  // register reset values
  localparam logic [REG_W-1:0]   RST_PNOISE = REG_W'(131072);
  localparam logic [REG_W-1:0]   RST_MNOISE = REG_W'(655);
  localparam logic [REG_W-1:0]   RST_ICOV   = REG_W'(65536);
  localparam logic [SPEED_W-1:0] RST_MAXSPD = SPEED_W'(6553600);
  localparam logic [SPEED_W-1:0] RST_MINSPD = '0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PNOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MNOISE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ICOV   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAXSPD = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MINSPD = CFG_IDX_W'(4);

  // action codes
  localparam logic [ACT_W-1:0] ACT_INIT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESET   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PREDICT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UPDATE  = 2'd3;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_RESET,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_MUL_VDT,
    OP_MUL_PDT,
    OP_MUL_KD,
    OP_MUL_PK,
    OP_MUL_KMH,
    OP_ADD_S,
    OP_ADD_P,
    OP_SET_P,
    OP_CLAMP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             active;
    logic             dt_zero;
    logic             out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/ksf_if.sv
// ----------------------------------------------------------------------------
// ksf channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ksf_item_if import ksf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] value;
  logic [DT_W-1:0]         time_step;

  modport source (output valid, action, value, time_step, input ready);
  modport sink   (input valid, action, value, time_step, output ready);
endinterface

interface ksf_result_if import ksf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_ms;
  logic [KMH_W-1:0]   speed_kmh;
  logic [COV_W-1:0]   covariance;
  logic               active;

  modport source (output valid, speed_ms, speed_kmh, covariance, active, input ready);
  modport sink   (input valid, speed_ms, speed_kmh, covariance, active, output ready);
endinterface

interface ksf_cfg_if import ksf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/ksf_ctrl.sv
// ----------------------------------------------------------------------------
// ksf_ctrl
// Sequencer: steps the datapath through init, reset, predict and update.
// ----------------------------------------------------------------------------
`default_nettype none

module ksf_ctrl import ksf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output      logic       item_ready,
  input  wire dp_status_t status,
  output      dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_RST,
    S_P_MUL_S,
    S_P_ADD_S,
    S_P_MUL_P,
    S_P_ADD_P,
    S_U_DIV0,
    S_U_DIV,
    S_U_MUL_S,
    S_U_ADD_S,
    S_U_MUL_P,
    S_U_SET_P,
    S_CLAMP,
    S_KMH,
    S_OUT
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE:    if (item_valid) state <= S_DECODE;
        S_DECODE: begin
          unique case (status.action)
            ACT_INIT:    state <= S_INIT;
            ACT_RESET:   state <= S_RST;
            ACT_PREDICT: state <= (status.active && !status.dt_zero) ? S_P_MUL_S : S_KMH;
            ACT_UPDATE:  state <= status.active ? S_U_DIV0 : S_KMH;
            default:     state <= S_KMH;
          endcase
        end
        S_INIT:    state <= S_CLAMP;
        S_RST:     state <= S_KMH;
        S_P_MUL_S: state <= S_P_ADD_S;
        S_P_ADD_S: state <= S_P_MUL_P;
        S_P_MUL_P: state <= S_P_ADD_P;
        S_P_ADD_P: state <= S_CLAMP;
        S_U_DIV0: begin
          state <= S_U_DIV;
          cnt   <= '0;
        end
        S_U_DIV: begin
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_U_MUL_S;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_U_MUL_S: state <= S_U_ADD_S;
        S_U_ADD_S: state <= S_U_MUL_P;
        S_U_MUL_P: state <= S_U_SET_P;
        S_U_SET_P: state <= S_CLAMP;
        S_CLAMP:   state <= S_KMH;
        S_KMH:     state <= S_OUT;
        S_OUT:     if (status.out_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd.load = (state == S_IDLE) && item_valid;
    unique case (state)
      S_INIT:    cmd.op = OP_INIT;
      S_RST:     cmd.op = OP_RESET;
      S_P_MUL_S: cmd.op = OP_MUL_VDT;
      S_P_ADD_S: cmd.op = OP_ADD_S;
      S_P_MUL_P: cmd.op = OP_MUL_PDT;
      S_P_ADD_P: cmd.op = OP_ADD_P;
      S_U_DIV0:  cmd.op = OP_DIV_START;
      S_U_DIV:   cmd.op = OP_DIV_STEP;
      S_U_MUL_S: cmd.op = OP_MUL_KD;
      S_U_ADD_S: cmd.op = OP_ADD_S;
      S_U_MUL_P: cmd.op = OP_MUL_PK;
      S_U_SET_P: cmd.op = OP_SET_P;
      S_CLAMP:   cmd.op = OP_CLAMP;
      S_KMH:     cmd.op = OP_MUL_KMH;
      S_OUT:     cmd.op = status.out_free ? OP_OUT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/ksf_datapath.sv
// ----------------------------------------------------------------------------
// ksf_datapath
// Filter state, config registers, shared multiplier, gain divider and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksf_datapath import ksf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dp_cmd_t                 cmd,
  output      dp_status_t              status,
  input  wire logic [ACT_W-1:0]        act_in,
  input  wire logic signed [VAL_W-1:0] value_in,
  input  wire logic [DT_W-1:0]         dt_in,
  ksf_result_if.source                 result,
  ksf_cfg_if.sink                      cfg
);

  // config
  logic [REG_W-1:0]   pnoise, mnoise, icov;
  logic [SPEED_W-1:0] max_spd, min_spd;

  // latched item
  logic [ACT_W-1:0]        act;
  logic signed [VAL_W-1:0] val;
  logic [DT_W-1:0]         dt;

  // filter state
  logic [SPEED_W-1:0] speed;
  logic [COV_W-1:0]   cov;
  logic               active;

  // working registers
  logic signed [SUM_W-1:0]  s_tmp;
  logic [DEN_W-1:0]         denom, rem;
  logic                     den_zero, dbit;
  logic [K_W-1:0]           quot;
  logic signed [PROD_W-1:0] prod;

  // result register
  logic               out_valid;
  logic [SPEED_W-1:0] out_speed;
  logic [KMH_W-1:0]   out_kmh;
  logic [COV_W-1:0]   out_cov;
  logic               out_active;

  // combinational
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [VAL_W:0]     diff;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [RS_W-1:0]    rs;
  logic signed [SUM_W-1:0]   s_sum, clamp_lo;
  logic [SPEED_W-1:0]        spd_clamped;
  logic [DEN_W-1:0]          p_sum;
  logic [COV_W-1:0]          p_add_sat, p_set_sat;
  logic [DEN_W:0]            trial;
  logic                      ge;

  assign diff = $signed({val[VAL_W-1], val}) - $signed({2'b00, speed});

  always_comb begin
    case (cmd.op)
      OP_MUL_VDT: begin
        mul_a = MUL_A_W'(val);
        mul_b = MUL_B_W'(dt);
      end
      OP_MUL_PDT: begin
        mul_a = MUL_A_W'(pnoise);
        mul_b = MUL_B_W'(dt);
      end
      OP_MUL_KD: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MUL_B_W'(quot);
      end
      OP_MUL_PK: begin
        mul_a = MUL_A_W'(cov);
        mul_b = MUL_B_W'(ONE_K - quot);
      end
      default: begin
        mul_a = MUL_A_W'(speed);
        mul_b = MUL_B_W'(C36);
      end
    endcase
  end

  // round to nearest, halves up, then drop the fraction
  assign prod_rnd = prod + $signed({{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
  assign rs       = $signed(prod_rnd[PROD_W-1:FRAC_BITS]);

  assign s_sum     = $signed({{(SUM_W-SPEED_W){1'b0}}, speed}) + SUM_W'(rs);
  assign p_sum     = {1'b0, cov} + DEN_W'(rs);
  assign p_add_sat = p_sum[COV_W] ? COV_MAX : p_sum[COV_W-1:0];
  assign p_set_sat = (rs[RS_W-1:COV_W] != '0) ? COV_MAX : rs[COV_W-1:0];

  // min first, then max: max wins when the bounds cross
  assign clamp_lo    = (s_tmp < $signed(SUM_W'(min_spd))) ? $signed(SUM_W'(min_spd)) : s_tmp;
  assign spd_clamped = (clamp_lo > $signed(SUM_W'(max_spd))) ? max_spd
                                                             : clamp_lo[SPEED_W-1:0];

  // restoring divide step
  assign trial = {rem, dbit};
  assign ge    = !den_zero && (trial >= {1'b0, denom});

  assign status.action   = act;
  assign status.active   = active;
  assign status.dt_zero  = (dt == '0);
  assign status.out_free = !out_valid || result.ready;

  assign cfg.ready = 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pnoise    <= RST_PNOISE;
      mnoise    <= RST_MNOISE;
      icov      <= RST_ICOV;
      max_spd   <= RST_MAXSPD;
      min_spd   <= RST_MINSPD;
      speed     <= '0;
      cov       <= COV_W'(RST_ICOV);
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_PNOISE: pnoise  <= cfg.data;
          REG_MNOISE: mnoise  <= cfg.data;
          REG_ICOV:   icov    <= cfg.data;
          REG_MAXSPD: max_spd <= cfg.data[SPEED_W-1:0];
          REG_MINSPD: min_spd <= cfg.data[SPEED_W-1:0];
          default: ;
        endcase
      end

      unique case (cmd.op)
        OP_INIT: begin
          cov    <= COV_W'(icov);
          active <= 1'b1;
        end
        OP_RESET: begin
          speed  <= '0;
          cov    <= COV_W'(icov);
          active <= 1'b0;
        end
        OP_ADD_P: cov   <= p_add_sat;
        OP_SET_P: cov   <= p_set_sat;
        OP_CLAMP: speed <= spd_clamped;
        default: ;
      endcase

      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= act_in;
      val <= value_in;
      dt  <= dt_in;
    end

    unique case (cmd.op) inside
      OP_MUL_VDT, OP_MUL_PDT, OP_MUL_KD, OP_MUL_PK, OP_MUL_KMH: begin
        prod <= mul_a * mul_b;
      end
      OP_INIT:  s_tmp <= SUM_W'(val);
      OP_ADD_S: s_tmp <= s_sum;
      OP_DIV_START: begin
        denom    <= {1'b0, cov} + DEN_W'(mnoise);
        den_zero <= (cov == '0) && (mnoise == '0);
        rem      <= DEN_W'(cov[COV_W-1:1]);
        dbit     <= cov[0];
        quot     <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= ge ? DEN_W'(trial - {1'b0, denom}) : trial[DEN_W-1:0];
        quot <= {quot[K_W-2:0], ge};
        dbit <= 1'b0;
      end
      OP_OUT: begin
        out_speed  <= speed;
        out_kmh    <= rs[KMH_W-1:0];
        out_cov    <= cov;
        out_active <= active;
      end
      default: ;
    endcase
  end

  assign result.valid      = out_valid;
  assign result.speed_ms   = out_speed;
  assign result.speed_kmh  = out_kmh;
  assign result.covariance = out_cov;
  assign result.active     = out_active;

endmodule

`default_nettype wire

### hdl/scalar_kalman_speed_fusion_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_speed_fusion_core
// One-state Kalman filter fusing accelerometer and GPS speed.
// ----------------------------------------------------------------------------
// Usage:
//  - item:   valid/ready input; action (init, reset, predict, GPS update),
//            signed value and time_step. One item in flight at a time.
//  - result: valid/ready output; one item per input item with speed in m/s
//            and km/h, covariance and the active flag. Held in an output
//            register, so the next input item is taken while it waits.
//  - cfg:    register writes (index, data), always ready; write only while
//            no item is in flight.
// An ignored predict/update (filter inactive, or predict with zero time_step) still gives a result.
// The GPS update uses the gain divider: a restoring divider that
// produces one quotient bit per cycle. All products go through
// a single shared 27x19 multiplier, one product per cycle.
// Reset (rst, synchronous): registers to defaults, speed 0, covariance to
// the initial covariance default, filter inactive, no result pending.
// Receiver stall: the sequencer parks until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_speed_fusion_core import ksf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ksf_item_if.sink     item,
  ksf_result_if.source result,
  ksf_cfg_if.sink      cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  ksf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // state, arithmetic and result register
  ksf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .act_in   (item.action),
    .value_in (item.value),
    .dt_in    (item.time_step),
    .result   (result),
    .cfg      (cfg)
  );

  // only one item in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("input accepted while an item is in flight");

  // result appears only from the sequencer's output step
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.op) == OP_OUT)
    else $error("result valid without output step");

  // an inactive filter always reports zero speed
  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.active |-> result.speed_ms == '0)
    else $error("inactive filter with nonzero speed");

endmodule

`default_nettype wire
